@@ rtl/adsr_pkg.sv @@
package adsr_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned DELTA_W  = 16;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [LEVEL_W-1:0] LVL_PEAK = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_GATE_ON  = 2'd1,
    OP_GATE_OFF = 2'd2,
    OP_RESET    = 2'd3
  } op_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } cfg_reg_e;

  // sequencer, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ELAP = 6'b000010,
    S_MUL  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } seq_e;

endpackage

@@ rtl/adsr_if.sv @@
interface adsr_in_if;
  import adsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [DELTA_W-1:0] delta_time;

  modport source (output valid, output op, output delta_time, input ready);
  modport sink (input valid, input op, input delta_time, output ready);
endinterface

interface adsr_out_if;
  import adsr_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [PHASE_W-1:0] phase;

  modport source (output valid, output level, output phase, input ready);
  modport sink (input valid, input level, input phase, output ready);
endinterface

@@ rtl/adsr_envelope_generator.sv @@
// Linear ADSR envelope generator. Each request on in_i carries an op (tick, gate on, gate off,
// reset to idle) and a millisecond delta used only by ticks; each request yields exactly one
// result on out_o with the envelope level (0..255) and phase (0 idle, 1 attack, 2 decay,
// 3 sustain, 4 release) after it. A tick adds its delta to a wrapping 32-bit millisecond clock
// and steps the phase; inside a ramp the level moves by floor(elapsed*range/time) from its start, exact to the bit.
// One request is in flight at a time and in_i.ready is high only while the sequencer is idle.
// A tick that lands inside a ramp walks the sequencer in order: the accepting cycle does the
// clock add, S_ELAP the elapsed-time subtract and end-of-phase compare, S_MUL an MSB-first
// shift-and-add multiply of elapsed by the range, S_DIV a restoring divide by the phase time
// (one quotient bit a cycle), S_FIN forms the level and S_OUT loads the output register; only
// then can the next request be accepted. A tick that ends or holds a phase skips S_MUL, S_DIV
// and S_FIN, and any other request goes straight to S_OUT. The result register keeps its value
// until taken, and the next request is accepted while it waits; only its own load waits for
// the register to free up. Timing registers are written over the APB port at byte offsets 0
// (attack), 4 (decay), 8 (sustain) and 12 (release); the user must write them only while idle,
// and the block itself does not enforce it.
module adsr_envelope_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  adsr_in_if.sink                      in_i,
  adsr_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adsr_pkg::PADDR_W-1:0] paddr,
  input  logic [adsr_pkg::PDATA_W-1:0] pwdata,
  output logic [adsr_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import adsr_pkg::*;

  // configuration
  logic [DELTA_W-1:0] attack_time_q, decay_time_q, release_time_q;
  logic [LEVEL_W-1:0] sustain_level_q;
  logic               cfg_wr;
  cfg_reg_e           cfg_idx;

  // envelope state
  seq_e               seq_q, seq_d;
  logic [TIME_W-1:0]  time_now_q, time_now_d;
  logic [TIME_W-1:0]  phase_start_q, phase_start_d;
  phase_e             phase_q, phase_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [LEVEL_W-1:0] rel_level_q, rel_level_d;

  // serial multiply / divide datapath
  logic [DELTA_W-1:0]         span_q, span_d;
  logic [DELTA_W-1:0]         mcand_q, mcand_d;
  logic [LEVEL_W-1:0]         mplr_q, mplr_d;
  logic [DELTA_W+LEVEL_W-1:0] acc_q, acc_d;
  logic [2:0]                 cnt_q, cnt_d;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [LEVEL_W-1:0] out_level_q;
  phase_e             out_phase_q;
  logic               out_load;

  logic [TIME_W-1:0]  elapsed;
  logic [DELTA_W-1:0] span_sel;
  logic               ramp_done;
  logic [DELTA_W:0]   trial;
  logic [DELTA_W:0]   diff;
  logic               fits;
  logic [LEVEL_W-1:0] quo;

  // ---------------------------------------------------------------------------
  // apb register file
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[3:2]);

  always_comb begin
    case (cfg_idx)
      REG_ATTACK:  prdata = {{(PDATA_W-DELTA_W){1'b0}}, attack_time_q};
      REG_DECAY:   prdata = {{(PDATA_W-DELTA_W){1'b0}}, decay_time_q};
      REG_SUSTAIN: prdata = {{(PDATA_W-LEVEL_W){1'b0}}, sustain_level_q};
      REG_RELEASE: prdata = {{(PDATA_W-DELTA_W){1'b0}}, release_time_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_time_q   <= '0;
      decay_time_q    <= '0;
      sustain_level_q <= '0;
      release_time_q  <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ATTACK:  attack_time_q   <= pwdata[DELTA_W-1:0];
        REG_DECAY:   decay_time_q    <= pwdata[DELTA_W-1:0];
        REG_SUSTAIN: sustain_level_q <= pwdata[LEVEL_W-1:0];
        REG_RELEASE: release_time_q  <= pwdata[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // phase timing
  // ---------------------------------------------------------------------------
  // elapsed wraps modulo 2^32 just like the clock itself
  assign elapsed = time_now_q - phase_start_q;

  always_comb begin
    case (phase_q)
      PH_ATTACK: span_sel = attack_time_q;
      PH_DECAY:  span_sel = decay_time_q;
      default:   span_sel = release_time_q;
    endcase
  end

  // zero time, or elapsed at or past the limit, ends the phase
  assign ramp_done = (span_sel == '0) || (|elapsed[TIME_W-1:DELTA_W]) ||
                     (elapsed[DELTA_W-1:0] >= span_sel);

  // restoring divide step: remainder lives in the top of acc, dividend bits
  // leave at bit 7 while quotient bits enter at bit 0
  assign trial = {acc_q[DELTA_W+LEVEL_W-1:LEVEL_W], acc_q[LEVEL_W-1]};
  assign diff  = trial - {1'b0, span_q};
  assign fits  = (trial >= {1'b0, span_q});
  assign quo   = acc_q[LEVEL_W-1:0];

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_i.ready = (seq_q == S_IDLE);
  assign out_load   = (seq_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    seq_d         = seq_q;
    time_now_d    = time_now_q;
    phase_start_d = phase_start_q;
    phase_d       = phase_q;
    level_d       = level_q;
    rel_level_d   = rel_level_q;
    span_d        = span_q;
    mcand_d       = mcand_q;
    mplr_d        = mplr_q;
    acc_d         = acc_q;
    cnt_d         = cnt_q;

    case (seq_q)
      S_IDLE: begin
        if (in_i.valid) begin
          seq_d = S_OUT;
          case (op_e'(in_i.op))
            OP_TICK: begin
              time_now_d = time_now_q + {{(TIME_W-DELTA_W){1'b0}}, in_i.delta_time};
              seq_d      = S_ELAP;
            end
            OP_GATE_ON: begin
              phase_d       = PH_ATTACK;
              phase_start_d = time_now_q;
            end
            OP_GATE_OFF: begin
              // ignored while idle or already releasing
              if (phase_q != PH_IDLE && phase_q != PH_RELEASE) begin
                rel_level_d   = level_q;
                phase_d       = PH_RELEASE;
                phase_start_d = time_now_q;
              end
            end
            default: begin
              phase_d = PH_IDLE;
              level_d = '0;
            end
          endcase
        end
      end

      S_ELAP: begin
        seq_d   = S_OUT;
        span_d  = span_sel;
        mcand_d = elapsed[DELTA_W-1:0];
        acc_d   = '0;
        cnt_d   = '0;
        case (phase_q)
          PH_ATTACK: begin
            if (ramp_done) begin
              level_d       = LVL_PEAK;
              phase_d       = PH_DECAY;
              phase_start_d = time_now_q;
            end else begin
              mplr_d = LVL_PEAK;
              seq_d  = S_MUL;
            end
          end
          PH_DECAY: begin
            if (ramp_done) begin
              level_d       = sustain_level_q;
              phase_d       = PH_SUSTAIN;
              phase_start_d = time_now_q;
            end else begin
              mplr_d = LVL_PEAK - sustain_level_q;
              seq_d  = S_MUL;
            end
          end
          PH_SUSTAIN: begin
            level_d = sustain_level_q;
          end
          PH_RELEASE: begin
            if (ramp_done) begin
              level_d = '0;
              phase_d = PH_IDLE;
            end else begin
              mplr_d = rel_level_q;
              seq_d  = S_MUL;
            end
          end
          default: begin
            level_d = '0;
            phase_d = PH_IDLE;
          end
        endcase
      end

      S_MUL: begin
        // msb-first shift and add, one multiplier bit a cycle
        acc_d  = {acc_q[DELTA_W+LEVEL_W-2:0], 1'b0} +
                 {{LEVEL_W{1'b0}}, (mplr_q[LEVEL_W-1] ? mcand_q : '0)};
        mplr_d = {mplr_q[LEVEL_W-2:0], 1'b0};
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          seq_d = S_DIV;
        end
      end

      S_DIV: begin
        acc_d = {(fits ? diff[DELTA_W-1:0] : trial[DELTA_W-1:0]),
                 acc_q[LEVEL_W-2:0], fits};
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          seq_d = S_FIN;
        end
      end

      S_FIN: begin
        seq_d = S_OUT;
        case (phase_q)
          PH_ATTACK:  level_d = quo;
          PH_DECAY:   level_d = LVL_PEAK - quo;
          PH_RELEASE: level_d = rel_level_q - quo;
          default:    level_d = level_q;
        endcase
      end

      S_OUT: begin
        if (out_load) begin
          seq_d = S_IDLE;
        end
      end

      default: seq_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= S_IDLE;
      time_now_q    <= '0;
      phase_start_q <= '0;
      phase_q       <= PH_IDLE;
      level_q       <= '0;
      rel_level_q   <= '0;
    end else begin
      seq_q         <= seq_d;
      time_now_q    <= time_now_d;
      phase_start_q <= phase_start_d;
      phase_q       <= phase_d;
      level_q       <= level_d;
      rel_level_q   <= rel_level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    span_q  <= span_d;
    mcand_q <= mcand_d;
    mplr_q  <= mplr_d;
    acc_q   <= acc_d;
    cnt_q   <= cnt_d;
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_level_q <= level_q;
      out_phase_q <= phase_q;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.level = out_level_q;
  assign out_o.phase = out_phase_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // one request in flight: acceptance drops ready on the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request accepted while another is in flight");

  // the divide remainder always stays below the phase time
  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q == S_DIV |-> acc_q[DELTA_W+LEVEL_W-1:LEVEL_W] < span_q)
    else $error("divide remainder not below divisor");

  // a fresh result only ever comes out of the output-load step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(seq_q == S_OUT))
    else $error("result raised outside the output step");

  // a waiting result is not overwritten before it is taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> $stable(out_level_q) && $stable(out_phase_q))
    else $error("pending result overwritten");

endmodule

@@ tb/testbench.sv @@
module testbench;
  import adsr_pkg::*;

  // one predicted result: level and phase after a request
  typedef struct {
    logic [LEVEL_W-1:0] level;
    phase_e             phase;
  } env_out_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  adsr_in_if  req_bus ();
  adsr_out_if res_bus ();

  adsr_envelope_generator uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_bus),
    .out_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // envelope state as the block should hold it
  logic [TIME_W-1:0]  ms_clock;
  phase_e             env_phase;
  logic [TIME_W-1:0]  phase_origin;
  logic [LEVEL_W-1:0] env_level;
  logic [LEVEL_W-1:0] release_from;

  // timing registers as last written
  logic [15:0]        atk_ms;
  logic [15:0]        dcy_ms;
  logic [LEVEL_W-1:0] sus_level;
  logic [15:0]        rel_ms;

  // results still owed by the block, oldest first
  env_out_t           due_outputs[$];
  env_out_t           head_due;

  int unsigned        fail_count  = 0;
  int unsigned        items_sent  = 0;
  int unsigned        req_idle_pct = 0;
  int unsigned        res_idle_pct = 0;
  bit                 bus_live    = 1'b0;
  longint             valid_stamp = -1;

  // clock, period 8
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #32_000_000;
    $display("Verification failed");
    $finish;
  end

  // floor(elapsed * range / span), span never zero here
  function automatic logic [LEVEL_W-1:0] ramp_level(logic [TIME_W-1:0] elapsed,
                                                    logic [LEVEL_W-1:0] range,
                                                    logic [15:0] span);
    logic [63:0] prod;
    prod = 64'(elapsed) * 64'(range);
    return LEVEL_W'(prod / 64'(span));
  endfunction

  // advance the envelope by one request and return what the block should report
  function automatic env_out_t envelope_step(op_e op, logic [DELTA_W-1:0] delta);
    env_out_t          res;
    logic [TIME_W-1:0] elapsed;
    case (op)
      OP_TICK: begin
        ms_clock = ms_clock + TIME_W'(delta);
        elapsed  = ms_clock - phase_origin;
        case (env_phase)
          PH_ATTACK: begin
            if (atk_ms == 16'd0 || elapsed >= TIME_W'(atk_ms)) begin
              env_level    = LVL_PEAK;
              env_phase    = PH_DECAY;
              phase_origin = ms_clock;
            end else begin
              env_level = ramp_level(elapsed, LVL_PEAK, atk_ms);
            end
          end
          PH_DECAY: begin
            if (dcy_ms == 16'd0 || elapsed >= TIME_W'(dcy_ms)) begin
              env_level    = sus_level;
              env_phase    = PH_SUSTAIN;
              phase_origin = ms_clock;
            end else begin
              env_level = LVL_PEAK - ramp_level(elapsed, LVL_PEAK - sus_level, dcy_ms);
            end
          end
          PH_SUSTAIN: begin
            env_level = sus_level;
          end
          PH_RELEASE: begin
            if (rel_ms == 16'd0 || elapsed >= TIME_W'(rel_ms)) begin
              env_level = '0;
              env_phase = PH_IDLE;
            end else begin
              env_level = release_from - ramp_level(elapsed, release_from, rel_ms);
            end
          end
          default: begin
            env_level = '0;
            env_phase = PH_IDLE;
          end
        endcase
      end
      OP_GATE_ON: begin
        // level stays put until the next tick
        env_phase    = PH_ATTACK;
        phase_origin = ms_clock;
      end
      OP_GATE_OFF: begin
        if (env_phase != PH_IDLE && env_phase != PH_RELEASE) begin
          release_from = env_level;
          env_phase    = PH_RELEASE;
          phase_origin = ms_clock;
        end
      end
      default: begin
        // clock and phase origin survive a reset to idle
        env_phase = PH_IDLE;
        env_level = '0;
      end
    endcase
    res.level = env_level;
    res.phase = env_phase;
    return res;
  endfunction

  // at most one nonblocking write to valid per time step
  task automatic drive_valid(logic v);
    if (valid_stamp == $time) begin
      @(posedge clk_i);
    end
    req_bus.valid <= v;
    valid_stamp = $time;
  endtask

  // offer one request, hold it until taken, then log the result it owes
  task automatic send_item(op_e op, logic [DELTA_W-1:0] delta);
    int unsigned gap;
    gap = 0;
    while (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      drive_valid(1'b0);
      repeat (gap) @(posedge clk_i);
    end
    drive_valid(1'b1);
    req_bus.op         <= op;
    req_bus.delta_time <= delta;
    bus_live = 1'b1;
    do begin
      @(posedge clk_i);
    end while (!req_bus.ready);
    due_outputs.push_back(envelope_step(op, delta));
    items_sent++;
  endtask

  task automatic release_bus();
    if (bus_live) begin
      drive_valid(1'b0);
      bus_live = 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (due_outputs.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // write one timing register, then read it straight back; psel stays high
  task automatic set_register(cfg_reg_e idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    case (idx)
      REG_ATTACK:  atk_ms    = value;
      REG_DECAY:   dcy_ms    = value;
      REG_SUSTAIN: sus_level = value[LEVEL_W-1:0];
      default:     rel_ms    = value;
    endcase
    // back-to-back read of the same register
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    if (prdata !== PDATA_W'(value)) begin
      $display("%0t: register %s readback, expected %0d, got %0d",
               $time, idx.name(), value, prdata);
      fail_count++;
    end
  endtask

  // settings change only once the block has delivered everything
  task automatic apply_settings(logic [15:0] a, logic [15:0] d, logic [LEVEL_W-1:0] s,
                                logic [15:0] r);
    release_bus();
    wait_drained();
    set_register(REG_ATTACK, a);
    set_register(REG_DECAY, d);
    set_register(REG_SUSTAIN, 16'(s));
    set_register(REG_RELEASE, r);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_idling(int unsigned req_pct, int unsigned res_pct);
    req_idle_pct = req_pct;
    res_idle_pct = res_pct;
  endtask

  function automatic logic [15:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return 16'd0;
    if (r < 25) return 16'hFFFF;
    if (r < 80) return 16'($urandom_range(1, 300));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_sustain();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return LVL_PEAK;
    return LEVEL_W'($urandom_range(0, 255));
  endfunction

  // tick size scaled to the running phase so ramps get walked in a few steps
  function automatic logic [DELTA_W-1:0] pick_delta();
    int unsigned span;
    int unsigned r;
    case (env_phase)
      PH_ATTACK:  span = atk_ms;
      PH_DECAY:   span = dcy_ms;
      PH_RELEASE: span = rel_ms;
      default:    span = 64;
    endcase
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return DELTA_W'($urandom_range(0, 65535));
    return DELTA_W'($urandom_range(0, span / 3 + 1));
  endfunction

  // every time register zero: each timed phase ends on its first tick
  task automatic test_zero_times();
    apply_settings(16'd0, 16'd0, 8'd0, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'hFFFF);
    send_item(OP_GATE_ON, 16'hFFFF);
    send_item(OP_TICK, 16'd0);
    send_item(OP_TICK, 16'd1);
    send_item(OP_GATE_OFF, 16'd0);
    send_item(OP_TICK, 16'd0);
    send_item(OP_GATE_OFF, 16'hFFFF);
  endtask

  // longest times, full sustain, gate-off twice, retrigger out of release, reset
  task automatic test_extreme_times();
    apply_settings(16'hFFFF, 16'hFFFF, LVL_PEAK, 16'hFFFF);
    send_item(OP_GATE_ON, 16'd0);
    send_item(OP_TICK, 16'd1);
    send_item(OP_TICK, 16'd32767);
    send_item(OP_GATE_OFF, 16'd0);
    send_item(OP_GATE_OFF, 16'd0);
    send_item(OP_TICK, 16'd100);
    send_item(OP_GATE_ON, 16'hFFFF);
    send_item(OP_TICK, 16'hFFFF);
    send_item(OP_TICK, 16'd40000);
    send_item(OP_RESET, 16'hFFFF);
  endtask

  // a full envelope through every phase with short times
  task automatic test_full_cycle();
    apply_settings(16'd10, 16'd20, 8'd128, 16'd30);
    send_item(OP_GATE_ON, 16'd0);
    send_item(OP_TICK, 16'd3);
    send_item(OP_TICK, 16'd10);
    send_item(OP_TICK, 16'd7);
    send_item(OP_TICK, 16'd20);
    send_item(OP_GATE_OFF, 16'd0);
    send_item(OP_TICK, 16'd29);
    send_item(OP_TICK, 16'd1);
  endtask

  task automatic play_envelope();
    int unsigned n;
    send_item(OP_GATE_ON, DELTA_W'($urandom));
    n = $urandom_range(1, 10);
    repeat (n) begin
      // occasional stray request in the middle of a ramp
      if ($urandom_range(0, 9) == 0) begin
        send_item(op_e'($urandom_range(0, 3)), DELTA_W'($urandom));
      end else begin
        send_item(OP_TICK, pick_delta());
      end
    end
    if ($urandom_range(0, 7) != 0) begin
      send_item(OP_GATE_OFF, DELTA_W'($urandom));
    end
    n = $urandom_range(1, 6);
    repeat (n) send_item(OP_TICK, pick_delta());
  endtask

  task automatic test_random_envelopes(int unsigned budget);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(0, 3) == 0) begin
        apply_settings(pick_time(), pick_time(), pick_sustain(), pick_time());
      end
      play_envelope();
    end
  endtask

  // result side: random stalls on ready
  always @(posedge clk_i) begin
    res_bus.ready <= (res_idle_pct == 0) || ($urandom_range(0, 99) >= res_idle_pct);
  end

  // every taken result against the oldest owed one
  always @(posedge clk_i) begin
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (due_outputs.size() == 0) begin
        $display("%0t: result with none owed, level %0d phase %0d",
                 $time, res_bus.level, res_bus.phase);
        fail_count++;
      end else begin
        head_due = due_outputs.pop_front();
        if (res_bus.level !== head_due.level) begin
          $display("%0t: level mismatch, expected %0d, got %0d",
                   $time, head_due.level, res_bus.level);
          fail_count++;
        end
        if (res_bus.phase !== head_due.phase) begin
          $display("%0t: phase mismatch, expected %0d, got %0d",
                   $time, head_due.phase, res_bus.phase);
          fail_count++;
        end
      end
    end
  end

  initial begin
    // predictor matches the block straight out of reset
    ms_clock     = '0;
    env_phase    = PH_IDLE;
    phase_origin = '0;
    env_level    = '0;
    release_from = '0;
    atk_ms       = '0;
    dcy_ms       = '0;
    sus_level    = '0;
    rel_ms       = '0;

    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    req_bus.op         <= OP_TICK;
    req_bus.delta_time <= '0;
    drive_valid(1'b0);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sparse request gaps, heavy result stalls
    set_idling(6, 77);
    test_zero_times();
    test_extreme_times();
    test_full_cycle();
    test_random_envelopes(550);
    // heavy request gaps, sparse result stalls
    set_idling(77, 6);
    test_random_envelopes(550);
    // flat out
    set_idling(0, 0);
    test_random_envelopes(550);

    release_bus();
    wait_drained();
    // allow for anything stray after the last result
    repeat (24) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
